// File: src/olpd_pkg.sv
// ----------------------------------------------------------------------------
// olpd_pkg : shared types and codes for the ordered list core
// Request and response transfer formats, operation and status codes, and
// the per-cell control word.
// ----------------------------------------------------------------------------
package olpd_pkg;

   // operation selectors
   localparam logic [2:0] FN_APPEND   = 3'd0;
   localparam logic [2:0] FN_DEL_HEAD = 3'd1;
   localparam logic [2:0] FN_DEL_TAIL = 3'd2;
   localparam logic [2:0] FN_DEL_POS  = 3'd3;
   localparam logic [2:0] FN_READ     = 3'd4;

   // response status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_BADPOS  = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_INVALID = 3'd4;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] value_out;
      logic               last;
      logic [4:0]         count;
   } rsp_type;

   // per-cell update select
   typedef struct packed {
      logic load;       // take the appended value
      logic take_next;  // take the right-hand neighbour's value
      logic take_head;  // take the head cell's value (read-out wrap)
   } cell_ctrl_type;

endpackage

// File: src/olpd_cell.sv
// ----------------------------------------------------------------------------
// olpd_cell : one storage cell of the list chain
// Holds one element and updates from the append bus, its right-hand
// neighbour or the head cell, as the control word selects.
// ----------------------------------------------------------------------------
module olpd_cell (
   input  logic                   clock,
   input  olpd_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]     append_value,
   input  logic signed [31:0]     next_value,
   input  logic signed [31:0]     head_value,
   output logic signed [31:0]     value
);
   import olpd_pkg::*;

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;

   // select the next element value
   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = append_value;
      end else if (ctrl.take_next) begin
         value_in = next_value;
      end else if (ctrl.take_head) begin
         value_in = head_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: src/ordered_list_with_positional_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_list_with_positional_delete_core : bounded ordered list
// Append, delete head/tail/position and full read-out over a chain of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, head in cell 0. Append, the three
// deletes and every error answer each give one response; deletes close the
// gap by having the affected cells take their neighbour's value in
// parallel. During a read-out of n elements the chain rotates by one cell
// per cycle and the head cell is emitted each time, so after n steps the
// list is back in order. Results pass through a single output register; a
// new request is taken only when that register is empty or its response
// transfers in the same cycle, so a stall on the response side holds off
// the request side and pauses the rotation.
// ----------------------------------------------------------------------------
module ordered_list_with_positional_delete_core #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  olpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output olpd_pkg::rsp_type rsp_data
);
   import olpd_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = CNT_W + 8;

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               slot_free;
   logic               accept;
   logic               is_empty;
   logic               is_full;
   logic               pos_ok;
   logic               rd_last;
   logic               do_append;
   logic               do_remove;
   logic               do_rotate;
   logic [CMP_W-1:0]   rm_idx;
   logic [CMP_W-1:0]   count_ext;
   logic [CMP_W-1:0]   count_in_ext;
   logic [CMP_W-1:0]   pos_ext;

   logic signed [31:0] cell_value [DEPTH];
   cell_ctrl_type      cell_ctrl  [DEPTH];

   // handshake
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;

   // list status
   assign count_ext    = CMP_W'(count_ff);
   assign count_in_ext = CMP_W'(count_in);
   assign pos_ext      = CMP_W'(req_data.position);
   assign is_empty     = (count_ff == '0);
   assign is_full      = (count_ff == CNT_W'(DEPTH));
   assign pos_ok       = (req_data.position != 8'd0) && (pos_ext <= count_ext);
   assign rd_last      = (CMP_W'(rd_cnt_ff) + CMP_W'(1) == count_ext);

   // operation decode and response build
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_cnt_in    = rd_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      do_append    = 1'b0;
      do_remove    = 1'b0;
      do_rotate    = 1'b0;
      rm_idx       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = ST_OK;
               rsp_data_in.value_out = '0;
               rsp_data_in.last      = 1'b1;
               case (req_data.func)
                  FN_APPEND: begin
                     if (is_full) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        do_append = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  FN_DEL_HEAD: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        do_remove = 1'b1;
                        count_in  = count_ff - CNT_W'(1);
                     end
                  end
                  FN_DEL_TAIL: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  FN_DEL_POS: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else if (!pos_ok) begin
                        rsp_data_in.status = ST_BADPOS;
                     end else begin
                        do_remove = 1'b1;
                        rm_idx    = pos_ext - CMP_W'(1);
                        count_in  = count_ff - CNT_W'(1);
                     end
                  end
                  FN_READ: begin
                     if (is_empty) begin
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                        rsp_data_in  = rsp_data_ff;
                        state_in     = S_READ;
                        rd_cnt_in    = '0;
                     end
                  end
                  default: begin
                     rsp_data_in.status = ST_INVALID;
                  end
               endcase
               rsp_data_in.count = count_in_ext[4:0];
            end
         end
         S_READ: begin
            // emit the head and rotate the occupied cells by one
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = ST_OK;
               rsp_data_in.value_out = cell_value[0];
               rsp_data_in.last      = rd_last;
               rsp_data_in.count     = count_ext[4:0];
               do_rotate             = 1'b1;
               rd_cnt_in             = rd_cnt_ff + CNT_W'(1);
               if (rd_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_cnt_ff    <= rd_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // chain of cells, cell 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
      logic signed [31:0] next_value;

      assign cell_ctrl[i].load      = do_append && (count_ff == CNT_W'(i));
      assign cell_ctrl[i].take_next =
         (do_remove && (IDX >= rm_idx) && (IDX + CMP_W'(1) < count_ext)) ||
         (do_rotate && (IDX + CMP_W'(1) < count_ext));
      assign cell_ctrl[i].take_head = do_rotate && (IDX + CMP_W'(1) == count_ext);

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      olpd_cell u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[i]),
         .append_value (req_data.value),
         .next_value   (next_value),
         .head_value   (cell_value[0]),
         .value        (cell_value[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: dv/olpd_list_check_pkg.sv
// ----------------------------------------------------------------------------
// olpd_list_check_pkg : response checking for the ordered list core
// Keeps a mirror of the list, works out the responses owed for each accepted
// request and compares every returned response with the oldest one owed.
// ----------------------------------------------------------------------------
package olpd_list_check_pkg;
   import olpd_pkg::*;

   class olpd_list_scoreboard;
      int                 list_depth;
      logic signed [31:0] entries[$];
      rsp_type            owed_rsp[$];
      int                 errors;
      int                 requests;
      int                 responses;
      int                 readouts;
      int                 full_refusals;

      function new(int depth);
         list_depth    = depth;
         errors        = 0;
         requests      = 0;
         responses     = 0;
         readouts      = 0;
         full_refusals = 0;
      endfunction

      function int held();
         return entries.size();
      endfunction

      function int outstanding();
         return owed_rsp.size();
      endfunction

      // apply one accepted request to the mirror and queue its responses
      function void note_request(req_type req);
         rsp_type rsp;
         int      n;
         int      i;
         n = entries.size();
         requests++;
         rsp      = '0;
         rsp.last = 1'b1;
         case (req.func)
            FN_APPEND: begin
               if (n >= list_depth) begin
                  rsp.status = ST_FULL;
                  full_refusals++;
               end else begin
                  entries.push_back(req.value);
               end
            end
            FN_DEL_HEAD: begin
               if (n == 0) rsp.status = ST_EMPTY;
               else entries.delete(0);
            end
            FN_DEL_TAIL: begin
               if (n == 0) rsp.status = ST_EMPTY;
               else entries.delete(n - 1);
            end
            FN_DEL_POS: begin
               // empty list is reported ahead of a bad position
               if (n == 0) rsp.status = ST_EMPTY;
               else if (req.position == 0 || req.position > n) rsp.status = ST_BADPOS;
               else entries.delete(req.position - 1);
            end
            FN_READ: begin
               if (n == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  // one response per element, head first, last on the tail
                  readouts++;
                  for (i = 0; i < n; i++) begin
                     rsp.status    = ST_OK;
                     rsp.value_out = entries[i];
                     rsp.last      = (i == n - 1);
                     rsp.count     = n[4:0];
                     owed_rsp.push_back(rsp);
                  end
                  return;
               end
            end
            default: rsp.status = ST_INVALID;
         endcase
         n         = entries.size();
         rsp.count = n[4:0];
         owed_rsp.push_back(rsp);
      endfunction

      // compare one response transfer with the oldest owed response
      function void check_result(rsp_type got);
         rsp_type want;
         responses++;
         if (owed_rsp.size() == 0) begin
            errors++;
            if (errors <= 20)
               $display("%0t: response with none owed: status %0d value %0d last %0b count %0d",
                        $time, got.status, got.value_out, got.last, got.count);
            return;
         end
         want = owed_rsp.pop_front();
         if (got.status !== want.status || got.value_out !== want.value_out ||
             got.last !== want.last || got.count !== want.count) begin
            errors++;
            if (errors <= 20) begin
               $display("%0t: response mismatch, expected status %0d value %0d last %0b count %0d",
                        $time, want.status, want.value_out, want.last, want.count);
               $display("%0t:                    actual   status %0d value %0d last %0b count %0d",
                        $time, got.status, got.value_out, got.last, got.count);
            end
         end
      endfunction
   endclass

endpackage

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb : testbench for ordered_list_with_positional_delete_core
// Directed corner cases (empty list, full list, extreme values, bad
// positions, unknown operations) followed by random request sequences that
// alternately fill and drain the list, with random gaps on the request side
// and random stalls on the response side. Responses are checked in order.
// ----------------------------------------------------------------------------
module tb;
   import olpd_pkg::*;
   import olpd_list_check_pkg::*;

   localparam int         LIST_DEPTH       = 16;
   localparam int         RANDOM_REQUESTS  = 230;
   localparam logic [2:0] FN_FIRST_INVALID = 3'd5;
   localparam logic [2:0] FN_LAST_INVALID  = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // shared pacing controls: no_idle gives stretches without gaps or stalls
   bit no_idle   = 1'b0;
   bit grow_list = 1'b1;

   olpd_list_scoreboard list_sb = new(LIST_DEPTH);

   ordered_list_with_positional_delete_core #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // watch both channels; responses first so owed order is never disturbed
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) list_sb.check_result(rsp_data);
         if (req_valid && !req_stall) list_sb.note_request(req_data);
      end
   end

   // present one request after a random gap and hold it until the transfer
   task automatic drive_request(input req_type req);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic send_op(input logic [2:0] func, input logic [31:0] value,
                          input logic [7:0] position);
      req_type req;
      req.func     = func;
      req.value    = value;
      req.position = position;
      drive_request(req);
   endtask

   // random request, biased towards filling or draining the list
   function automatic req_type random_request();
      req_type req;
      int      held;
      int      pick;
      held         = list_sb.held();
      req.value    = $urandom;
      req.position = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < (grow_list ? 65 : 25)) begin
         req.func = FN_APPEND;
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0:       req.value = 32'h8000_0000;
               1:       req.value = 32'h7fff_ffff;
               2:       req.value = 32'h0000_0000;
               default: req.value = 32'hffff_ffff;
            endcase
         end
      end else begin
         pick = $urandom_range(0, 19);
         if (pick < 4) begin
            req.func = FN_DEL_HEAD;
         end else if (pick < 8) begin
            req.func = FN_DEL_TAIL;
         end else if (pick < 14) begin
            req.func = FN_DEL_POS;
            // mostly a position in range or just past the tail
            if ($urandom_range(0, 4) != 0) req.position = 8'($urandom_range(1, held + 1));
         end else if (pick < 18) begin
            req.func = FN_READ;
         end else begin
            req.func = 3'($urandom_range(FN_FIRST_INVALID, FN_LAST_INVALID));
         end
      end
      return req;
   endfunction

   // response side: random stall before each response transfer
   initial begin
      int hold;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do begin
            @(posedge clock);
         end while (!rsp_valid);
      end
   end

   // stimulus
   initial begin
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list: read-out and every delete report empty, an unknown operation reports invalid
      send_op(FN_READ, 32'h0, 8'd0);
      send_op(FN_DEL_HEAD, 32'h0, 8'd0);
      send_op(FN_DEL_TAIL, 32'h0, 8'd0);
      send_op(FN_DEL_POS, 32'h0, 8'd0);
      send_op(FN_LAST_INVALID, 32'hffff_ffff, 8'hff);

      // extreme values, then positions zero and past the tail
      send_op(FN_APPEND, 32'h8000_0000, 8'd0);
      send_op(FN_APPEND, 32'h7fff_ffff, 8'hff);
      send_op(FN_APPEND, 32'h0000_0000, 8'd0);
      send_op(FN_APPEND, 32'hffff_ffff, 8'd0);
      send_op(FN_DEL_POS, 32'h0, 8'd0);
      send_op(FN_DEL_POS, 32'h0, 8'hff);
      send_op(FN_READ, 32'h0, 8'd0);

      // fill to capacity, refuse one more, read the full list back, then delete the last position, head and tail
      repeat (LIST_DEPTH - 4) send_op(FN_APPEND, $urandom, 8'd0);
      send_op(FN_APPEND, 32'h1234_5678, 8'd0);
      send_op(FN_READ, 32'h0, 8'd0);
      send_op(FN_DEL_POS, 32'h0, 8'(LIST_DEPTH));
      send_op(FN_DEL_HEAD, 32'h0, 8'd0);
      send_op(FN_DEL_TAIL, 32'h0, 8'd0);

      // random sequences in alternating fill and drain phases
      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 30 == 0) grow_list = ~grow_list;
         no_idle = (i % 50) >= 40;
         drive_request(random_request());
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;

      // drain: let the last request be noted, then wait for every response
      @(posedge clock);
      while (list_sb.outstanding() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 4) @(posedge clock);

      $display("Run covered %0d requests and %0d responses, with %0d list read-outs",
               list_sb.requests, list_sb.responses, list_sb.readouts);
      $display("and %0d appends refused on a full list.", list_sb.full_refusals);
      if (list_sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog: slowest legal run is roughly 260 requests x 16 responses, each
   // behind a random stall, plus gaps; this allows several times that
   initial begin
      #6_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
